@@ hdl/tccw_pkg.sv @@
// shared types and constants for the text console cell writer
package tccw_pkg;

    localparam int ATTR_W      = 8;
    localparam int CHAR_W      = 8;
    localparam int CELL_W      = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0f;

    typedef struct packed {
        logic [1:0] pad;
        logic [6:0] read_col;
        logic [4:0] read_row;
        logic [7:0] char_code;
        logic [1:0] cmd;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } out_item_t;

endpackage

@@ hdl/tccw_ram.sv @@
// generic simple dual-port ram with registered read
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/text_console_cell_writer_top.sv @@
// text console engine: cell store with circular rows, cursor, scroll and clear
//
// channel  | dir | contents
// s_axis   | in  | one command per transfer
// m_axis   | out | cursor position and read cell, one per command
// cfg      | in  | text attribute write
//
// put and read go from ST_IDLE to ST_RESULT, which registers the result once the m_axis output register is free
// a scroll blanks one row through the ram write port
// a clear blanks the whole store, one cell per cycle
// after reset a sweep fills the store with blanks before s_axis_tready rises
// the next command is taken while a result still waits on m_axis
module text_console_cell_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cmd, char_code, read_row, read_col, zero pad
    input  logic [tccw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // cursor_col, cursor_row, cell_value, zero pad
    output logic [tccw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic [tccw_pkg::ATTR_W-1:0]       cfg_wr_data
);
    import tccw_pkg::*;

    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam logic [ROW_W:0]    ROWS_EXT = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_RESULT} state_t;

    state_t             state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [ATTR_W-1:0]  attr_reg;
    logic [1:0]         cmd_reg, cmd_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [ADDR_W-1:0]  sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]  sweep_last_reg, sweep_last_next;
    logic [CELL_W-1:0]  sweep_data_reg, sweep_data_next;
    logic               sweep_res_reg, sweep_res_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    in_item_t           in_item;
    logic [CELL_W-1:0]  blank;
    logic               adv_row;
    logic [ADDR_W-1:0]  top_base;
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] t,
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, t} + {1'b0, r};
        if (sum >= ROWS_EXT) begin
            sum = sum - ROWS_EXT;
        end
        return ADDR_W'(sum) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

    assign in_item       = s_axis_tdata;
    assign blank         = {attr_reg, CH_SPACE};
    assign top_base      = ADDR_W'(top_reg) * ADDR_W'(COLUMNS);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        top_next        = top_reg;
        cmd_next        = cmd_reg;
        rd_ok_next      = rd_ok_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        sweep_data_next = sweep_data_reg;
        sweep_res_next  = sweep_res_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        adv_row         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = sweep_addr_reg;
        ram_wdata       = sweep_data_reg;
        ram_re          = 1'b0;
        ram_raddr       = cell_addr(top_reg, ROW_W'(in_item.read_row),
                                    COL_W'(in_item.read_col));

        unique case (state_reg)
            ST_SWEEP: begin
                ram_we = 1'b1;
                if (sweep_addr_reg == sweep_last_reg) begin
                    state_next = sweep_res_reg ? ST_RESULT : ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd_next   = in_item.cmd;
                    state_next = ST_RESULT;
                    unique case (in_item.cmd)
                        CMD_PUT: begin
                            priority if (in_item.char_code == CH_NEWLINE) begin
                                col_next = '0;
                                adv_row  = 1'b1;
                            end else if (in_item.char_code == CH_BACKSPACE) begin
                                if (col_reg != '0) begin
                                    col_next = col_reg - 1'b1;
                                end else if (row_reg != '0) begin
                                    row_next = row_reg - 1'b1;
                                    col_next = LAST_COL;
                                end
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = cell_addr(top_reg, row_reg, col_reg);
                                ram_wdata = {attr_reg, in_item.char_code};
                                if (col_reg == LAST_COL) begin
                                    col_next = '0;
                                    adv_row  = 1'b1;
                                end else begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                            if (adv_row) begin
                                if (row_reg == LAST_ROW) begin
                                    top_next        = (top_reg == LAST_ROW) ? '0
                                                                            : top_reg + 1'b1;
                                    sweep_addr_next = top_base;
                                    sweep_last_next = top_base + ADDR_W'(COLUMNS - 1);
                                    sweep_data_next = blank;
                                    sweep_res_next  = 1'b1;
                                    state_next      = ST_SWEEP;
                                end else begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            col_next        = '0;
                            row_next        = '0;
                            top_next        = '0;
                            sweep_addr_next = '0;
                            sweep_last_next = LAST_ADDR;
                            sweep_data_next = blank;
                            sweep_res_next  = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                        CMD_READ: begin
                            ram_re     = 1'b1;
                            rd_ok_next = (32'(in_item.read_row) < 32'(ROWS))
                                      && (32'(in_item.read_col) < 32'(COLUMNS));
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.pad        = '0;
                    m_data_next.cursor_col = 7'(col_reg);
                    m_data_next.cursor_row = 5'(row_reg);
                    m_data_next.cell_value = (cmd_reg == CMD_READ && rd_ok_reg) ? ram_rdata
                                                                                : '0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            col_reg        <= '0;
            row_reg        <= '0;
            top_reg        <= '0;
            attr_reg       <= RESET_ATTR;
            cmd_reg        <= CMD_PUT;
            rd_ok_reg      <= 1'b0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= LAST_ADDR;
            sweep_data_reg <= {RESET_ATTR, CH_SPACE};
            sweep_res_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            top_reg        <= top_next;
            cmd_reg        <= cmd_next;
            rd_ok_reg      <= rd_ok_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            sweep_data_reg <= sweep_data_next;
            sweep_res_reg  <= sweep_res_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                attr_reg <= cfg_wr_data;
            end
        end
        m_data_reg <= m_data_next;
    end

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule
